>>> sv/dlv_pkg.sv
// shared types and constants of the decimal list validator
package dlv_pkg;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 9;
    localparam int STATUS_W = 3;
    localparam int RES_W    = STATUS_W + VALUE_W + POS_W;
    localparam int M_DATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0]  CHAR_PLUS  = 8'h2b;
    localparam logic [VALUE_W-1:0] MAG_SAFE   = 32'd214748364;
    localparam logic [VALUE_W-1:0] INT_MAX    = 32'd2147483647;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BAD      = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_DUP      = 3'd3,
        ST_FULL     = 3'd4,
        ST_FAILED   = 3'd5
    } status_t;

    typedef struct packed {
        logic [VALUE_W-1:0] magnitude;
        logic               negative;
        logic               at_first;
        logic               bad;
        logic               ovf;
    } tok_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
        status_t            status;
    } res_t;

endpackage

>>> sv/dlv_token_parser.sv
// per-character token parser: sign, digit accumulation and error flags
module dlv_token_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        fire,
    input  logic                        list_start,
    input  logic                        has_char,
    input  logic [dlv_pkg::CHAR_W-1:0]  character,
    input  logic                        token_end,
    output dlv_pkg::tok_t               tok
);

    localparam dlv_pkg::tok_t TOK_CLEAR = '{magnitude: '0, negative: 1'b0,
                                            at_first: 1'b1, bad: 1'b0, ovf: 1'b0};

    dlv_pkg::tok_t               tok_reg;
    dlv_pkg::tok_t               base;
    dlv_pkg::tok_t               tok_next;
    logic [3:0]                  digit;
    logic [dlv_pkg::VALUE_W-1:0] times_ten;
    logic [dlv_pkg::VALUE_W-1:0] sum;
    logic [dlv_pkg::VALUE_W-1:0] limit;
    logic                        is_sign;
    logic                        is_digit;

    always_comb begin
        base      = list_start ? TOK_CLEAR : tok_reg;
        digit     = 4'(character - dlv_pkg::CHAR_ZERO);
        times_ten = {base.magnitude[28:0], 3'b000} + {base.magnitude[30:0], 1'b0};
        sum       = times_ten + {28'd0, digit};
        limit     = dlv_pkg::INT_MAX + {31'd0, base.negative};
        is_sign   = (character == dlv_pkg::CHAR_PLUS) || (character == dlv_pkg::CHAR_MINUS);
        is_digit  = (character >= dlv_pkg::CHAR_ZERO) && (character <= dlv_pkg::CHAR_NINE);
        tok_next  = base;
        if (has_char) begin
            tok_next.at_first = 1'b0;
            if (base.at_first && is_sign) begin
                tok_next.negative = (character == dlv_pkg::CHAR_MINUS);
            end else if (!is_digit) begin
                tok_next.bad = 1'b1;
            end else if (!base.ovf) begin
                if (base.magnitude > dlv_pkg::MAG_SAFE) begin
                    tok_next.ovf = 1'b1;
                end else if (sum > limit) begin
                    tok_next.ovf = 1'b1;
                end else begin
                    tok_next.magnitude = sum;
                end
            end
        end
    end

    assign tok = tok_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= TOK_CLEAR;
        end else if (fire) begin
            tok_reg <= token_end ? TOK_CLEAR : tok_next;
        end
    end

endmodule

>>> sv/dlv_value_store.sv
// value table with a sequencer that walks it through one comparator
module dlv_value_store #(
    parameter int MAX_VALUES = 512
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic          clear,
    input  dlv_pkg::tok_t tok,
    input  logic          res_take,
    output logic          busy,
    output logic          res_valid,
    output dlv_pkg::res_t res
);

    localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CW = $clog2(MAX_VALUES + 1);

    typedef enum logic [1:0] {
        IDLE,
        PREP,
        WALK,
        REPORT
    } state_t;

    state_t                      state_reg;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               issue_idx_reg;
    logic                        cmp_vld_reg;
    logic                        failed_reg;
    logic                        dup_reg;
    logic                        bad_reg;
    logic                        ovf_reg;
    logic                        neg_reg;
    logic [dlv_pkg::VALUE_W-1:0] mag_reg;
    logic [dlv_pkg::VALUE_W-1:0] v_reg;
    logic [dlv_pkg::VALUE_W-1:0] rdata_reg;
    logic [dlv_pkg::VALUE_W-1:0] mem [MAX_VALUES];

    logic              hit;
    logic              rd_en;
    logic              wr_en;
    logic              full;
    dlv_pkg::status_t  status;

    always_comb begin
        hit   = cmp_vld_reg && (rdata_reg == v_reg);
        rd_en = (state_reg == WALK) && !hit && (issue_idx_reg != count_reg);
        full  = (count_reg >= CW'(MAX_VALUES));
        if (failed_reg) begin
            status = dlv_pkg::ST_FAILED;
        end else if (bad_reg) begin
            status = dlv_pkg::ST_BAD;
        end else if (ovf_reg) begin
            status = dlv_pkg::ST_OVERFLOW;
        end else if (dup_reg) begin
            status = dlv_pkg::ST_DUP;
        end else if (full) begin
            status = dlv_pkg::ST_FULL;
        end else begin
            status = dlv_pkg::ST_OK;
        end
        wr_en        = (state_reg == REPORT) && res_take && (status == dlv_pkg::ST_OK);
        res.status   = status;
        res.value    = (status == dlv_pkg::ST_OK) ? v_reg : '0;
        res.position = dlv_pkg::POS_W'(count_reg);
    end

    assign busy      = (state_reg != IDLE);
    assign res_valid = (state_reg == REPORT);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[AW-1:0]] <= v_reg;
        end
        if (rd_en) begin
            rdata_reg <= mem[issue_idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            issue_idx_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            failed_reg    <= 1'b0;
            dup_reg       <= 1'b0;
        end else begin
            unique case (state_reg)
                IDLE: begin
                    if (clear) begin
                        count_reg  <= '0;
                        failed_reg <= 1'b0;
                    end
                    if (start) begin
                        mag_reg   <= tok.magnitude;
                        neg_reg   <= tok.negative;
                        bad_reg   <= tok.bad;
                        ovf_reg   <= tok.ovf;
                        dup_reg   <= 1'b0;
                        state_reg <= PREP;
                    end
                end
                PREP: begin
                    v_reg         <= neg_reg ? (~mag_reg + 32'd1) : mag_reg;
                    issue_idx_reg <= '0;
                    cmp_vld_reg   <= 1'b0;
                    state_reg     <= (failed_reg || bad_reg || ovf_reg) ? REPORT : WALK;
                end
                WALK: begin
                    if (hit) begin
                        dup_reg     <= 1'b1;
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= REPORT;
                    end else if (issue_idx_reg == count_reg) begin
                        cmp_vld_reg <= 1'b0;
                        state_reg   <= REPORT;
                    end else begin
                        issue_idx_reg <= issue_idx_reg + CW'(1);
                        cmp_vld_reg   <= 1'b1;
                    end
                end
                REPORT: begin
                    if (res_take) begin
                        if (status == dlv_pkg::ST_OK) begin
                            count_reg <= count_reg + CW'(1);
                        end else begin
                            failed_reg <= 1'b1;
                        end
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/decimal_list_validator_unit.sv
// top level of the decimal list validator
// Characters of decimal tokens enter one beat each; a beat without tlast is taken while the
// block is not busy. A beat with tlast starts the end-of-token check: PREP forms the signed
// value, then WALK walks the value table through its single read port and one comparator,
// one entry per cycle, and REPORT reports; PREP skips to REPORT when the token already
// failed or the list is failed. No characters are taken until REPORT hands the result on,
// which waits while the output register still holds an unaccepted result.
// A result waits in the output register while the next characters are taken. The value
// table needs no clearing; only entries written in the current list are read.
module decimal_list_validator_unit #(
    parameter int MAX_VALUES = 512
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // character
    input  logic [1:0]                    s_tuser,   // list_start, has_char
    input  logic                          s_tlast,   // token_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dlv_pkg::M_DATA_W-1:0]  m_tdata    // status, value, position, zero pad
);

    logic          s_fire;
    logic          busy;
    logic          res_valid;
    logic          out_free;
    logic          m_tvalid_reg;
    dlv_pkg::tok_t tok;
    dlv_pkg::res_t res;
    logic [dlv_pkg::M_DATA_W-1:0] m_tdata_reg;

    assign s_tready = !busy;
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    dlv_token_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (s_fire),
        .list_start (s_tuser[0]),
        .has_char   (s_tuser[1]),
        .character  (s_tdata),
        .token_end  (s_tlast),
        .tok        (tok)
    );

    dlv_value_store #(
        .MAX_VALUES (MAX_VALUES)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_fire && s_tlast),
        .clear     (s_fire && s_tuser[0]),
        .tok       (tok),
        .res_take  (out_free),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && out_free) begin
            m_tvalid_reg <= 1'b1;
            m_tdata_reg  <= dlv_pkg::M_DATA_W'(res);
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> sv/dlv_checker.sv
// port-level checks of the decimal list validator and their binding
module dlv_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dlv_pkg::M_DATA_W-1:0]  m_tdata
);

    // stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // failed tokens carry a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != dlv_pkg::ST_OK) |-> (m_tdata[34:3] == 32'd0))
        else $error("nonzero value with failing status");

    // status code in range, pad bits clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= dlv_pkg::ST_FAILED) &&
                     (m_tdata[dlv_pkg::M_DATA_W-1:dlv_pkg::RES_W] == '0))
        else $error("bad status code or pad bits");

    // token end starts the table check, input stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during token check");

endmodule

bind decimal_list_validator_unit dlv_checker u_dlv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/tb_decimal_list_validator_unit.sv
// testbench for the decimal list validator: random and directed token streams checked by a scoreboard
`timescale 1ns / 100ps

module tb_decimal_list_validator_unit;

    localparam int          MAX_VALUES   = 512;
    localparam int          RANDOM_ITEMS = 900;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          TAIL_CYCLES  = 40;
    localparam int          HOLD_CYCLES  = 400;
    localparam longint unsigned EDGE_MAGS [12] = '{
        64'd2147483647, 64'd2147483648, 64'd2147483649, 64'd2147483646,
        64'd2147483639, 64'd2147483640, 64'd2147483650, 64'd214748364,
        64'd214748365, 64'd2147483657, 64'd4294967295, 64'd0
    };

    class token_result_scoreboard;
        dlv_pkg::res_t               pending_results[$];
        logic [dlv_pkg::VALUE_W-1:0] stored_values [MAX_VALUES];
        int unsigned                 value_count;
        logic [dlv_pkg::VALUE_W-1:0] magnitude;
        bit                          negative;
        bit                          at_first;
        bit                          bad_seen;
        bit                          ovf_seen;
        bit                          list_failed;
        int                          errors;

        function new();
            value_count = 0;
            list_failed = 0;
            errors      = 0;
            clear_token();
        endfunction

        function void clear_token();
            magnitude = '0;
            negative  = 0;
            at_first  = 1;
            bad_seen  = 0;
            ovf_seen  = 0;
        endfunction

        function void take_char(logic [dlv_pkg::CHAR_W-1:0] ch);
            bit                          first;
            logic [dlv_pkg::VALUE_W-1:0] dig;
            logic [dlv_pkg::VALUE_W-1:0] lim;
            logic [dlv_pkg::VALUE_W-1:0] prod;
            first    = at_first;
            at_first = 0;
            if (first && (ch == dlv_pkg::CHAR_PLUS || ch == dlv_pkg::CHAR_MINUS)) begin
                negative = (ch == dlv_pkg::CHAR_MINUS);
                return;
            end
            if (ch < dlv_pkg::CHAR_ZERO || ch > dlv_pkg::CHAR_NINE) begin
                bad_seen = 1;
                return;
            end
            if (ovf_seen)
                return;
            dig = dlv_pkg::VALUE_W'(ch - dlv_pkg::CHAR_ZERO);
            if (magnitude > dlv_pkg::MAG_SAFE) begin
                ovf_seen = 1;
                return;
            end
            prod = magnitude * 32'd10;
            lim  = dlv_pkg::INT_MAX + dlv_pkg::VALUE_W'(negative) - dig;
            if (prod > lim) begin
                ovf_seen = 1;
                return;
            end
            magnitude = prod + dig;
        endfunction

        function dlv_pkg::status_t close_token(output logic [dlv_pkg::VALUE_W-1:0] val);
            logic [dlv_pkg::VALUE_W-1:0] v;
            val = '0;
            if (list_failed)
                return dlv_pkg::ST_FAILED;
            if (bad_seen) begin
                list_failed = 1;
                return dlv_pkg::ST_BAD;
            end
            if (ovf_seen) begin
                list_failed = 1;
                return dlv_pkg::ST_OVERFLOW;
            end
            v = negative ? -magnitude : magnitude;
            for (int i = 0; i < value_count; i++) begin
                if (stored_values[i] == v) begin
                    list_failed = 1;
                    return dlv_pkg::ST_DUP;
                end
            end
            if (value_count >= MAX_VALUES) begin
                list_failed = 1;
                return dlv_pkg::ST_FULL;
            end
            stored_values[value_count] = v;
            value_count++;
            val = v;
            return dlv_pkg::ST_OK;
        endfunction

        function void note_beat(bit list_start, bit has_char, logic [dlv_pkg::CHAR_W-1:0] ch,
                                bit token_end);
            dlv_pkg::res_t               r;
            logic [dlv_pkg::VALUE_W-1:0] v;
            if (list_start) begin
                value_count = 0;
                list_failed = 0;
                clear_token();
            end
            if (has_char)
                take_char(ch);
            if (token_end) begin
                r.position = dlv_pkg::POS_W'(value_count);
                r.status   = close_token(v);
                r.value    = v;
                pending_results.push_back(r);
                clear_token();
            end
        endfunction

        task report(string msg);
            if (errors < 50)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [dlv_pkg::M_DATA_W-1:0] data);
            dlv_pkg::res_t got;
            dlv_pkg::res_t want;
            got = data[dlv_pkg::RES_W-1:0];
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result status %0d value %0d position %0d",
                                 got.status, $signed(got.value), got.position));
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, wanted %0d (position %0d)",
                                 got.status, want.status, want.position));
            if (got.value !== want.value)
                report($sformatf("value %0d, wanted %0d (position %0d)",
                                 $signed(got.value), $signed(want.value), want.position));
            if (got.position !== want.position)
                report($sformatf("position %0d, wanted %0d", got.position, want.position));
        endtask
    endclass

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata  = '0;
    logic [1:0]                    s_tuser  = '0;
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [dlv_pkg::M_DATA_W-1:0]  m_tdata;

    token_result_scoreboard sb = new();

    logic [dlv_pkg::CHAR_W-1:0] tok_chars[$];
    int                         list_vals[$];
    int                         item_count  = 0;
    int                         burst_left  = 0;
    bit                         gap_on      = 1;
    bit                         noise_on    = 0;
    bit                         rx_hold_req = 0;
    int                         cycle_count = 0;

    decimal_list_validator_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic send_beat(input bit list_start, input bit has_char,
                             input logic [dlv_pkg::CHAR_W-1:0] ch, input bit token_end);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if (gap_on) begin
                gap = $urandom_range(1, 8);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= {has_char, list_start};
        s_tlast  <= token_end;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(list_start, has_char, ch, token_end);
        item_count++;
        burst_left--;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending_results.size() != 0);
    endtask

    task automatic send_token(input bit list_start, input bit sep_end);
        int n;
        n = tok_chars.size();
        for (int i = 0; i < n; i++) begin
            if (noise_on && $urandom_range(0, 99) < 3)
                send_beat(($urandom_range(0, 9) == 0), 1'b0, 8'($urandom_range(0, 255)), 1'b0);
            send_beat(list_start && i == 0, 1'b1, tok_chars[i], (i == n - 1) && !sep_end);
        end
        if (n == 0 || sep_end)
            send_beat(list_start && n == 0, 1'b0, 8'($urandom_range(0, 255)), 1'b1);
        tok_chars.delete();
    endtask

    task automatic send_text(input bit list_start, input string txt);
        for (int i = 0; i < txt.len(); i++)
            tok_chars.push_back(txt[i]);
        send_token(list_start, 1'b0);
    endtask

    task automatic push_mag(input longint unsigned m);
        string txt;
        txt = $sformatf("%0d", m);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) tok_chars.push_back(dlv_pkg::CHAR_ZERO);
        for (int i = 0; i < txt.len(); i++)
            tok_chars.push_back(txt[i]);
    endtask

    task automatic push_signed(input int v);
        longint m;
        list_vals.push_back(v);
        if (v < 0) begin
            tok_chars.push_back(dlv_pkg::CHAR_MINUS);
            m = -longint'(v);
        end else begin
            if ($urandom_range(0, 2) == 0)
                tok_chars.push_back(dlv_pkg::CHAR_PLUS);
            m = v;
        end
        push_mag(m);
    endtask

    function automatic logic [dlv_pkg::CHAR_W-1:0] junk_char();
        case ($urandom_range(0, 3))
            0:       return dlv_pkg::CHAR_ZERO - 8'd1;
            1:       return dlv_pkg::CHAR_NINE + 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [dlv_pkg::CHAR_W-1:0] sign_char();
        return ($urandom_range(0, 1) == 0) ? dlv_pkg::CHAR_PLUS : dlv_pkg::CHAR_MINUS;
    endfunction

    task automatic build_token(input bit clean);
        int kind;
        kind = clean ? $urandom_range(0, 3) : $urandom_range(0, 11);
        case (kind)
            0: push_signed($urandom);
            1: push_signed(int'($urandom_range(0, 19999)) - 10000);
            2: begin
                case ($urandom_range(0, 2))
                    1: tok_chars.push_back(dlv_pkg::CHAR_PLUS);
                    2: tok_chars.push_back(dlv_pkg::CHAR_MINUS);
                    default: ;
                endcase
                push_mag(EDGE_MAGS[$urandom_range(0, 11)]);
            end
            3: begin
                if (list_vals.size() > 0 && $urandom_range(0, 3) == 0)
                    push_signed(list_vals[$urandom_range(0, list_vals.size() - 1)]);
                else
                    push_signed($urandom_range(0, 99));
            end
            4: push_signed(int'($urandom_range(0, 15)) - 8);
            5, 7: begin
                if ($urandom_range(0, 1) == 0)
                    tok_chars.push_back(sign_char());
                tok_chars.push_back(dlv_pkg::CHAR_ZERO + 8'($urandom_range(1, 9)));
                repeat ($urandom_range(10, 13))
                    tok_chars.push_back(dlv_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
                if (kind == 7)
                    tok_chars.insert($urandom_range(0, tok_chars.size()), junk_char());
            end
            6: begin
                push_signed($urandom);
                tok_chars.insert($urandom_range(0, tok_chars.size()), junk_char());
            end
            8: begin
                push_signed($urandom_range(0, 999));
                tok_chars.insert($urandom_range(1, tok_chars.size()), sign_char());
            end
            9: ;
            10: tok_chars.push_back(sign_char());
            default: begin
                tok_chars.push_back(sign_char());
                push_signed($urandom_range(0, 999));
            end
        endcase
    endtask

    // receiver: own stall pattern, plus one long hold-off on request
    initial begin
        int hold_left;
        int mode_left;
        int mode;
        hold_left = 0;
        mode_left = 0;
        mode      = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (rx_hold_req) begin
                rx_hold_req = 0;
                hold_left   = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int  n_tok;
        bit  clean;
        bit  hold_done;
        bit  pause_done;
        hold_done  = 0;
        pause_done = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero forms, duplicate zero, failed list, misplaced sign, idle beats, byte extremes
        send_text(1'b1, "-0");
        send_text(1'b0, "+");
        send_text(1'b0, "");
        send_text(1'b1, "");
        send_text(1'b0, "5-");
        send_beat(1'b1, 1'b0, 8'ha5, 1'b0);
        send_beat(1'b0, 1'b1, 8'hff, 1'b1);
        send_beat(1'b1, 1'b1, 8'h00, 1'b1);
        send_beat(1'b1, 1'b1, dlv_pkg::CHAR_NINE, 1'b0);
        send_beat(1'b0, 1'b0, 8'h5a, 1'b0);
        send_beat(1'b0, 1'b1, dlv_pkg::CHAR_NINE, 1'b1);
        send_text(1'b0, "-");
        send_text(1'b0, "+-3");
        wait_drained();

        while (item_count < RANDOM_ITEMS) begin
            clean    = ($urandom_range(0, 9) < 7);
            n_tok    = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 12);
            gap_on   = ($urandom_range(0, 4) != 0);
            noise_on = !clean || ($urandom_range(0, 3) == 0);
            list_vals.delete();
            for (int k = 0; k < n_tok; k++) begin
                build_token(clean);
                send_token(k == 0, ($urandom_range(0, 9) == 0));
            end
            if (!hold_done && item_count > 300) begin
                hold_done   = 1;
                rx_hold_req = 1;
            end
            if (!pause_done && item_count > 600) begin
                pause_done = 1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> decimal_list_validator_unit.f
sv/dlv_pkg.sv
sv/dlv_token_parser.sv
sv/dlv_value_store.sv
sv/decimal_list_validator_unit.sv
sv/dlv_checker.sv
sim/tb_decimal_list_validator_unit.sv
